### rtl/aes128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// S-boxes, round constants and the round and key-schedule functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned Rounds   = 10;
  localparam int unsigned KeyBytes = 16;
  localparam int unsigned BlockW   = 8 * KeyBytes;

  localparam logic REG_KEY_HI = 1'b0;
  localparam logic REG_KEY_LO = 1'b1;

  localparam logic ACT_ENC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BlockW-1:0] state;
    logic [BlockW-1:0] key;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*c) -: 8] = SBOX[s[BlockW-1-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic logic [BlockW-1:0] inv_sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r+4*((c+r)%4)) -: 8] = INV_SBOX[s[BlockW-1-8*(r+4*c) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic logic [BlockW-1:0] mix_cols(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    logic [7:0]        a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      o[BlockW-1-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[BlockW-9-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[BlockW-17-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[BlockW-25-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return a ^ xtime(xtime(xtime(a)));
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    return a ^ xtime(a) ^ xtime(xtime(xtime(a)));
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    return a ^ xtime(xtime(a)) ^ xtime(xtime(xtime(a)));
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    return xtime(a) ^ xtime(xtime(a)) ^ xtime(xtime(xtime(a)));
  endfunction

  function automatic logic [BlockW-1:0] inv_mix_cols(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    logic [7:0]        a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[BlockW-1-32*c -: 8];
      a1 = s[BlockW-9-32*c -: 8];
      a2 = s[BlockW-17-32*c -: 8];
      a3 = s[BlockW-25-32*c -: 8];
      o[BlockW-1-32*c -: 8]  = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      o[BlockW-9-32*c -: 8]  = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      o[BlockW-17-32*c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      o[BlockW-25-32*c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    return o;
  endfunction

  function automatic logic [BlockW-1:0] key_fwd(input logic [BlockW-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rc, 24'h000000};
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [BlockW-1:0] key_bwd(input logic [BlockW-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3) ^ {rc, 24'h000000};
    return {p0, p1, p2, p3};
  endfunction

endpackage
`default_nettype wire

### rtl/aes128_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 round cell
// One cipher round with its on-the-fly round key step, registered.
// ----------------------------------------------------------------------------
module aes128_round_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire aes128_pkg::item_t item_i,
  input  wire logic [7:0]        rc_enc_i,
  input  wire logic [7:0]        rc_dec_i,
  input  wire logic              last_i,
  output logic                   valid_o,
  output aes128_pkg::item_t      item_o
);

  logic              valid_q;
  aes128_pkg::item_t item_q, item_d;
  logic [aes128_pkg::BlockW-1:0] key_nxt, t_enc, t_dec;

  always_comb begin
    if (item_i.action == aes128_pkg::ACT_DEC) begin
      key_nxt = aes128_pkg::key_bwd(item_i.key, rc_dec_i);
    end else begin
      key_nxt = aes128_pkg::key_fwd(item_i.key, rc_enc_i);
    end
    t_enc = aes128_pkg::sub_shift(item_i.state);
    if (!last_i) begin
      t_enc = aes128_pkg::mix_cols(t_enc);
    end
    t_enc = t_enc ^ key_nxt;
    t_dec = aes128_pkg::inv_sub_shift(item_i.state) ^ key_nxt;
    if (!last_i) begin
      t_dec = aes128_pkg::inv_mix_cols(t_dec);
    end
    item_d.action = item_i.action;
    item_d.key    = key_nxt;
    item_d.state  = (item_i.action == aes128_pkg::ACT_DEC) ? t_dec : t_enc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

### rtl/aes128_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Key registers and a sequencer that derives the last round key.
// ----------------------------------------------------------------------------
module aes128_key_sched (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [63:0]                   cfg_data_i,
  output logic [aes128_pkg::BlockW-1:0]      key_o,
  output logic [aes128_pkg::BlockW-1:0]      key_last_o,
  output logic                               busy_o
);

  logic [63:0] key_hi_q, key_hi_d, key_lo_q, key_lo_d;
  logic [aes128_pkg::BlockW-1:0] work_q, work_d;
  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;

  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    work_d   = work_q;
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes128_pkg::REG_KEY_HI: key_hi_d = cfg_data_i;
        aes128_pkg::REG_KEY_LO: key_lo_d = cfg_data_i;
        default:                key_hi_d = key_hi_q;
      endcase
      work_d = {key_hi_d, key_lo_d};
      busy_d = 1'b1;
      cnt_d  = 4'd1;
    end else if (busy_q) begin
      work_d = aes128_pkg::key_fwd(work_q, aes128_pkg::rcon(cnt_q));
      if (cnt_q == 4'(aes128_pkg::Rounds)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      work_q   <= '0;
      busy_q   <= 1'b1;
      cnt_q    <= 4'd1;
    end else begin
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      work_q   <= work_d;
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
    end
  end

  assign key_o      = {key_hi_q, key_lo_q};
  assign key_last_o = work_q;
  assign busy_o     = busy_q;

  a_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_q && (cnt_q == 4'd1))
    else $error("key write did not restart the schedule");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 4'd0) && (cnt_q <= 4'(aes128_pkg::Rounds)))
    else $error("schedule step out of range");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cfg_we_i && (cnt_q == 4'(aes128_pkg::Rounds)) |=> !busy_q)
    else $error("schedule did not finish");

endmodule
`default_nettype wire

### rtl/aes128_block_cipher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled ECB encrypt/decrypt pipeline of ten round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action and one 128-bit
//   block; output channel (out_valid_o / out_stall_i) carries the result.
//   An item moves when valid is high and stall is low.
//   Stages: one key-add stage and ten round cells, the last cell being the
//   output register.
//   Throughput: one item per cycle unless stalled; each cell holds one item
//   and the round key it needs, deriving the next round key as it passes.
//   Key: write key_hi (index 0) and key_lo (index 1) on the cfg port. Each
//   write starts a schedule run that derives the last round key for
//   decryption; the input is stalled while it runs.
//   Reset: pipeline empties, key clears to zero and the schedule run for
//   the all-zero key follows, with the input stalled.
//   Receiver stall: a held result stays put; cells behind it keep filling
//   empty slots and stall only when full.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [63:0] data_hi_i,
  input  wire logic [63:0] data_lo_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_hi_o,
  output logic [63:0]      result_lo_o
);

  localparam int unsigned NStages = aes128_pkg::Rounds + 1;

  logic [aes128_pkg::BlockW-1:0] key, key_last;
  logic                          key_busy;

  logic              v   [NStages];
  logic              go  [NStages];
  aes128_pkg::item_t itm [NStages];

  logic              v0_q;
  aes128_pkg::item_t it0_q, it0_d;
  logic              in_take;

  aes128_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key),
    .key_last_o (key_last),
    .busy_o     (key_busy)
  );

  always_comb begin
    go[NStages-1] = !v[NStages-1] || !out_stall_i;
    for (int i = NStages - 2; i >= 0; i--) begin
      go[i] = !v[i] || go[i+1];
    end
  end

  assign in_stall_o = key_busy || !go[0];
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    it0_d.action = action_i;
    it0_d.key    = (action_i == aes128_pkg::ACT_DEC) ? key_last : key;
    it0_d.state  = {data_hi_i, data_lo_i} ^ it0_d.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (go[0]) begin
      v0_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      it0_q <= it0_d;
    end
  end

  assign v[0]   = v0_q;
  assign itm[0] = it0_q;

  for (genvar r = 1; r < NStages; r++) begin : g_cell
    aes128_round_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (go[r]),
      .valid_i  (v[r-1]),
      .item_i   (itm[r-1]),
      .rc_enc_i (aes128_pkg::rcon(4'(r))),
      .rc_dec_i (aes128_pkg::rcon(4'(NStages - r))),
      .last_i   (r == NStages - 1),
      .valid_o  (v[r]),
      .item_o   (itm[r])
    );
  end

  assign out_valid_o = v[NStages-1];
  assign result_hi_o = itm[NStages-1].state[127:64];
  assign result_lo_o = itm[NStages-1].state[63:0];

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_busy |-> in_stall_o)
    else $error("item taken during key schedule");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && !go[0] |=> v0_q && $stable(it0_q))
    else $error("first stage dropped an item");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !key_busy && in_stall_o |-> v0_q && out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
